// ===== rtl/bmsirq_pkg.sv =====
// bmsirq_pkg: shared types and constants of the bank mapper with scanline irq
package bmsirq_pkg;

    localparam int PRG_RAM_BYTES      = 8192;
    localparam int PRG_RAM_BITS       = $clog2(PRG_RAM_BYTES);
    localparam int DEF_PRG_ADDR_BITS  = 21;
    localparam int DEF_CHR_ADDR_BITS  = 18;
    localparam int MADDR_W            = 21;
    localparam int CFG_ADDR_W         = 4;
    localparam int CFG_DATA_W         = 32;

    localparam logic [7:0] RST_PRG_MASK   = 8'd7;
    localparam logic [7:0] RST_CHR_MASK   = 8'd127;
    localparam logic       RST_CHR_PRES   = 1'b1;
    localparam logic [1:0] RST_INIT_MIRR  = 2'd0;

    // mapper register decode, address anded with this mask
    localparam logic [15:0] WR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] WR_BANK_SEL    = 16'h8000;
    localparam logic [15:0] WR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] WR_MIRROR      = 16'hA000;
    localparam logic [15:0] WR_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] WR_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] WR_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] WR_IRQ_ENABLE  = 16'hE001;

    localparam logic [1:0] MIRR_VERT  = 2'd0;
    localparam logic [1:0] MIRR_HORIZ = 2'd1;

    typedef enum logic [1:0] {
        CFG_PRG_MASK  = 2'd0,
        CFG_CHR_MASK  = 2'd1,
        CFG_CHR_PRES  = 2'd2,
        CFG_INIT_MIRR = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        REQ_CPU_RD = 2'd0,
        REQ_CPU_WR = 2'd1,
        REQ_PPU_RD = 2'd2,
        REQ_PPU_WR = 2'd3
    } t_req_type;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_RAM = 3'd1,
        TGT_PRG_ROM = 3'd2,
        TGT_CHR_ROM = 3'd3,
        TGT_NT_RAM  = 3'd4,
        TGT_REG     = 3'd5,
        TGT_ZERO    = 3'd6
    } t_target;

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] addr;
        logic [7:0]  data_in;
        logic        read_only;
    } t_req_item;

    typedef struct packed {
        t_target              target;
        logic [MADDR_W-1:0]   mapped_addr;
        logic                 write_enable;
        logic [7:0]           write_data;
        logic                 claimed;
        logic                 irq_line;
    } t_res_item;

    typedef struct packed {
        logic [7:0] prg_mask;
        logic [7:0] chr_mask;
        logic       chr_present;
        logic [1:0] init_mirror;
        logic       mirror_load;
    } t_cfg;

endpackage

// ===== rtl/bmsirq_cfg.sv =====
// bmsirq_cfg: apb configuration registers
module bmsirq_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmsirq_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bmsirq_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bmsirq_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                               pready,
    output bmsirq_pkg::t_cfg                   o_cfg
);

    logic [7:0] r_prg_mask;
    logic [7:0] r_chr_mask;
    logic       r_chr_pres;
    logic [1:0] r_init_mirr;
    logic       wr_en;
    bmsirq_pkg::t_cfg_reg reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = bmsirq_pkg::t_cfg_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_mask  <= bmsirq_pkg::RST_PRG_MASK;
            r_chr_mask  <= bmsirq_pkg::RST_CHR_MASK;
            r_chr_pres  <= bmsirq_pkg::RST_CHR_PRES;
            r_init_mirr <= bmsirq_pkg::RST_INIT_MIRR;
        end else if (wr_en) begin
            case (reg_idx)
                bmsirq_pkg::CFG_PRG_MASK:  r_prg_mask  <= pwdata[7:0];
                bmsirq_pkg::CFG_CHR_MASK:  r_chr_mask  <= pwdata[7:0];
                bmsirq_pkg::CFG_CHR_PRES:  r_chr_pres  <= pwdata[0];
                bmsirq_pkg::CFG_INIT_MIRR: r_init_mirr <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            bmsirq_pkg::CFG_PRG_MASK:  prdata = {24'd0, r_prg_mask};
            bmsirq_pkg::CFG_CHR_MASK:  prdata = {24'd0, r_chr_mask};
            bmsirq_pkg::CFG_CHR_PRES:  prdata = {31'd0, r_chr_pres};
            bmsirq_pkg::CFG_INIT_MIRR: prdata = {30'd0, r_init_mirr};
            default:                   prdata = '0;
        endcase
    end

    // mirroring write also reloads the live mirror mode
    assign o_cfg.prg_mask    = r_prg_mask;
    assign o_cfg.chr_mask    = r_chr_mask;
    assign o_cfg.chr_present = r_chr_pres;
    assign o_cfg.init_mirror = pwdata[1:0];
    assign o_cfg.mirror_load = wr_en && (reg_idx == bmsirq_pkg::CFG_INIT_MIRR);

endmodule

// ===== rtl/bmsirq_core.sv =====
// bmsirq_core: mapper state, irq counter and address translation of one item
module bmsirq_core #(
    parameter int PRG_ADDR_BITS = bmsirq_pkg::DEF_PRG_ADDR_BITS,
    parameter int CHR_ADDR_BITS = bmsirq_pkg::DEF_CHR_ADDR_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  bmsirq_pkg::t_req_item i_req,
    input  bmsirq_pkg::t_cfg      i_cfg,
    output bmsirq_pkg::t_res_item o_res
);

    localparam int MW = bmsirq_pkg::MADDR_W;
    localparam logic [MW-1:0] PRG_MASK = MW'((64'd1 << PRG_ADDR_BITS) - 64'd1);
    localparam logic [MW-1:0] CHR_MASK = MW'((64'd1 << CHR_ADDR_BITS) - 64'd1);

    logic [7:0] r_bank_sel, n_bank_sel;
    logic [7:0] r_bank_regs [8];
    logic [7:0] n_bank_regs [8];
    logic [7:0] r_irq_latch, n_irq_latch;
    logic [7:0] r_irq_cnt, n_irq_cnt;
    logic       r_reload, n_reload;
    logic       r_irq_en, n_irq_en;
    logic       r_irq_pend, n_irq_pend;
    logic       r_prev_a12, n_prev_a12;
    logic [1:0] r_mirror, n_mirror;

    logic [1:0]  prg_slot;
    logic [7:0]  prg_second;
    logic [7:0]  prg_bank;
    logic [MW-1:0] prg_addr;
    logic [2:0]  chr_slot;
    logic [2:0]  chr_idx;
    logic [7:0]  chr_bank;
    logic [MW-1:0] chr_addr;
    logic [13:0] ppu_addr;
    logic [MW-1:0] nt_addr;
    logic        we;
    logic        a12;

    // prg window: slot 1 is bank 7, slot 3 fixed last, slots 0/2 swap on mode
    always_comb begin
        prg_slot   = i_req.addr[14:13];
        prg_second = i_cfg.prg_mask - 8'd1;
        if (prg_slot == 2'd1) begin
            prg_bank = r_bank_regs[7];
        end else if (prg_slot == 2'd3) begin
            prg_bank = i_cfg.prg_mask;
        end else if ((prg_slot == 2'd0) != r_bank_sel[6]) begin
            prg_bank = r_bank_regs[6];
        end else begin
            prg_bank = prg_second;
        end
        prg_addr = {prg_bank & i_cfg.prg_mask, i_req.addr[12:0]} & PRG_MASK;
    end

    // chr window: 2 kb pairs in the low half, 1 kb banks in the high half, halves swapped by bank_sel[7]
    always_comb begin
        ppu_addr = i_req.addr[13:0];
        chr_slot = ppu_addr[12:10] ^ {r_bank_sel[7], 2'b00};
        if (!chr_slot[2]) begin
            chr_idx  = {2'b00, chr_slot[1]};
            chr_bank = {r_bank_regs[chr_idx][7:1], chr_slot[0]};
        end else begin
            chr_idx  = chr_slot - 3'd2;
            chr_bank = r_bank_regs[chr_idx];
        end
        chr_addr = {3'd0, chr_bank & i_cfg.chr_mask, ppu_addr[9:0]} & CHR_MASK;
    end

    always_comb begin
        case (r_mirror)
            bmsirq_pkg::MIRR_VERT:  nt_addr = MW'(ppu_addr[10:0]);
            bmsirq_pkg::MIRR_HORIZ: nt_addr = MW'({ppu_addr[11], ppu_addr[9:0]});
            default:                nt_addr = MW'(ppu_addr[11:0]);
        endcase
    end

    always_comb begin
        n_bank_sel  = r_bank_sel;
        n_bank_regs = r_bank_regs;
        n_irq_latch = r_irq_latch;
        n_irq_cnt   = r_irq_cnt;
        n_reload    = r_reload;
        n_irq_en    = r_irq_en;
        n_irq_pend  = r_irq_pend;
        n_prev_a12  = r_prev_a12;
        n_mirror    = r_mirror;
        a12         = ppu_addr[12];
        we          = 1'b0;
        o_res       = '0;
        o_res.target = bmsirq_pkg::TGT_NONE;

        case (i_req.req_type)
            bmsirq_pkg::REQ_CPU_RD, bmsirq_pkg::REQ_CPU_WR: begin
                if (i_req.addr[15]) begin
                    if (i_req.req_type == bmsirq_pkg::REQ_CPU_RD) begin
                        o_res.target      = bmsirq_pkg::TGT_PRG_ROM;
                        o_res.mapped_addr = prg_addr;
                        o_res.claimed     = 1'b1;
                    end else begin
                        o_res.target = bmsirq_pkg::TGT_REG;
                        case (i_req.addr & bmsirq_pkg::WR_DECODE_MASK)
                            bmsirq_pkg::WR_BANK_SEL:  n_bank_sel = i_req.data_in;
                            bmsirq_pkg::WR_BANK_DATA:
                                n_bank_regs[r_bank_sel[2:0]] = i_req.data_in;
                            bmsirq_pkg::WR_MIRROR: begin
                                if (!r_mirror[1]) begin
                                    n_mirror = {1'b0, i_req.data_in[0]};
                                end
                            end
                            bmsirq_pkg::WR_IRQ_LATCH:  n_irq_latch = i_req.data_in;
                            bmsirq_pkg::WR_IRQ_RELOAD: n_reload = 1'b1;
                            bmsirq_pkg::WR_IRQ_DISABLE: begin
                                n_irq_pend = 1'b0;
                                n_irq_en   = 1'b0;
                            end
                            bmsirq_pkg::WR_IRQ_ENABLE: n_irq_en = 1'b1;
                            default: ;
                        endcase
                    end
                end else if (i_req.addr[14] && i_req.addr[13]) begin
                    o_res.target      = bmsirq_pkg::TGT_PRG_RAM;
                    o_res.mapped_addr = MW'(i_req.addr[bmsirq_pkg::PRG_RAM_BITS-1:0]);
                    o_res.claimed     = 1'b1;
                    we = (i_req.req_type == bmsirq_pkg::REQ_CPU_WR);
                end
            end
            default: begin
                // a12 rising edge clocks the scanline counter
                if (i_req.req_type == bmsirq_pkg::REQ_PPU_WR || !i_req.read_only) begin
                    if (!r_prev_a12 && a12) begin
                        if (r_irq_cnt == 8'd0 || r_reload) begin
                            n_reload  = 1'b0;
                            n_irq_cnt = r_irq_latch;
                        end else begin
                            n_irq_cnt = r_irq_cnt - 8'd1;
                        end
                        if (n_irq_cnt == 8'd0 && r_irq_en) begin
                            n_irq_pend = 1'b1;
                        end
                    end
                    n_prev_a12 = a12;
                end
                if (ppu_addr[13]) begin
                    o_res.target      = bmsirq_pkg::TGT_NT_RAM;
                    o_res.mapped_addr = nt_addr;
                    we = (i_req.req_type == bmsirq_pkg::REQ_PPU_WR);
                end else if (i_req.req_type == bmsirq_pkg::REQ_PPU_RD) begin
                    if (i_cfg.chr_present) begin
                        o_res.target      = bmsirq_pkg::TGT_CHR_ROM;
                        o_res.mapped_addr = chr_addr;
                    end else begin
                        o_res.target = bmsirq_pkg::TGT_ZERO;
                    end
                end
            end
        endcase

        o_res.write_enable = we;
        o_res.write_data   = we ? i_req.data_in : 8'd0;
        o_res.irq_line     = n_irq_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_sel  <= '0;
            r_bank_regs <= '{default: '0};
            r_irq_latch <= '0;
            r_irq_cnt   <= '0;
            r_reload    <= 1'b0;
            r_irq_en    <= 1'b0;
            r_irq_pend  <= 1'b0;
            r_prev_a12  <= 1'b0;
            r_mirror    <= bmsirq_pkg::RST_INIT_MIRR;
        end else begin
            if (i_fire) begin
                r_bank_sel  <= n_bank_sel;
                r_bank_regs <= n_bank_regs;
                r_irq_latch <= n_irq_latch;
                r_irq_cnt   <= n_irq_cnt;
                r_reload    <= n_reload;
                r_irq_en    <= n_irq_en;
                r_irq_pend  <= n_irq_pend;
                r_prev_a12  <= n_prev_a12;
            end
            if (i_cfg.mirror_load) begin
                r_mirror <= i_cfg.init_mirror;
            end else if (i_fire) begin
                r_mirror <= n_mirror;
            end
        end
    end

endmodule

// ===== rtl/bank_mapper_with_scanline_irq_unit.sv =====
// bank_mapper_with_scanline_irq_unit: top level, item pipeline around the mapper core
// an accepted item is held in the input register, then its result in the output register
// throughput: one item per cycle unless stalled; the single translation pass between
// the input and output registers sets that figure; output back-pressure stalls the pipeline
// reset: synchronous active-low, clears both valid flags, all mapper and irq state and
// loads the configuration registers with their defaults
module bank_mapper_with_scanline_irq_unit #(
    parameter int PRG_ADDR_BITS = bmsirq_pkg::DEF_PRG_ADDR_BITS,
    parameter int CHR_ADDR_BITS = bmsirq_pkg::DEF_CHR_ADDR_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  bmsirq_pkg::t_req_item              i_req_item,
    // result channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output bmsirq_pkg::t_res_item              o_res_item,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bmsirq_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [bmsirq_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bmsirq_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                               pready
);

    // input stage register
    logic                  r_in_valid;
    bmsirq_pkg::t_req_item r_in_item;
    // output stage register
    logic                  r_out_valid;
    bmsirq_pkg::t_res_item r_out_item;

    bmsirq_pkg::t_cfg      cfg;
    bmsirq_pkg::t_res_item core_res;
    logic                  advance;
    logic                  accept;

    // the item in the input register moves on when the output slot is free or draining;
    // the mapper state is updated on that same edge, so items are served strictly in order
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign accept  = i_valid && o_ready;

    bmsirq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bmsirq_core #(
        .PRG_ADDR_BITS (PRG_ADDR_BITS),
        .CHR_ADDR_BITS (CHR_ADDR_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_req   (r_in_item),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_req_item;
        end
        if (advance) begin
            r_out_item <= core_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_res_item = r_out_item;

endmodule
